// ----- sv/hsvrgb_pkg.sv -----
// hsvrgb_pkg: shared types and constants for the HSV to RGB converter.
// No dependencies; used by hsv_to_rgb_convert, hsvrgb_front, hsvrgb_back and hsvrgb_checker.
package hsvrgb_pkg;

  // Fixed widths of the pixel fields
  localparam int IN_W  = 18;
  localparam int OUT_W = 8;

  // Result class decided by the front end
  typedef enum logic [1:0] {
    KIND_BLACK,
    KIND_GREY,
    KIND_COLOR
  } kind_e;

  // Hue sector, 0..6 (6 acts as 0)
  typedef logic [2:0] sector_t;

  localparam sector_t SECT_0 = 3'd0;
  localparam sector_t SECT_1 = 3'd1;
  localparam sector_t SECT_2 = 3'd2;
  localparam sector_t SECT_3 = 3'd3;
  localparam sector_t SECT_4 = 3'd4;
  localparam sector_t SECT_5 = 3'd5;
  localparam sector_t SECT_6 = 3'd6;

  // Control group handed from front end to back end
  typedef struct packed {
    kind_e   kind;
    sector_t sector;
  } ctrl_t;

endpackage

// ----- sv/hsv_to_rgb_convert.sv -----
// hsv_to_rgb_convert: HSV to RGB pixel converter, top level.
// A pixel passes through the queue and the back-end stage registers before it shows on valid_o.
// Throughput: one pixel per clock; the back end never stalls, so busy stays low.
// The front end writes one queue entry per beat; the back end drains one per cycle while the queue is not empty.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid bits.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_fifo, hsvrgb_back.
module hsv_to_rgb_convert #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hsvrgb_pkg::IN_W-1:0]  hue_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0]  saturation_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0]  brightness_i,
  output logic                                valid_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]        red_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]        green_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]        blue_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam int CTW = $bits(hsvrgb_pkg::ctrl_t);
  localparam int QW = CTW + 3 * VW;

  hsvrgb_pkg::ctrl_t fr_ctrl, bk_ctrl;
  logic [VW-1:0]     fr_frac, fr_sat, fr_val;
  logic [VW-1:0]     bk_frac, bk_sat, bk_val;
  logic [QW-1:0]     q_wdata, q_rdata;
  logic              q_empty, q_full, accept;

  assign accept = start && !busy;
  assign busy   = q_full;

  hsvrgb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .ctrl_o       (fr_ctrl),
    .frac_o       (fr_frac),
    .sat_o        (fr_sat),
    .val_o        (fr_val)
  );

  assign q_wdata = {fr_ctrl, fr_frac, fr_sat, fr_val};

  hsvrgb_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (q_wdata),
    .pop_i   (!q_empty),
    .rdata_o (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign {bk_ctrl, bk_frac, bk_sat, bk_val} = q_rdata;

  hsvrgb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (!q_empty),
    .ctrl_i     (bk_ctrl),
    .frac_i     (bk_frac),
    .sat_i      (bk_sat),
    .val_i      (bk_val),
    .valid_o    (valid_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

endmodule

// ----- sv/hsvrgb_front.sv -----
// hsvrgb_front: range checks, hue sector split and fraction mirroring.
// Depends on hsvrgb_pkg.
module hsvrgb_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic signed [hsvrgb_pkg::IN_W-1:0] hue_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] saturation_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] brightness_i,
  output hsvrgb_pkg::ctrl_t                  ctrl_o,
  output logic [FRAC_BITS:0]                 frac_o,
  output logic [FRAC_BITS:0]                 sat_o,
  output logic [FRAC_BITS:0]                 val_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam int CW = (VW > hsvrgb_pkg::IN_W) ? VW : hsvrgb_pkg::IN_W;
  localparam int HW = VW + 3;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

  logic [CW-1:0]  h_mag, s_mag, v_mag;
  logic           h_ok, s_ok, v_ok;
  logic [HW-1:0]  h6;
  logic [2:0]     sector;
  logic [VW-1:0]  f_raw;

  // magnitude of the non-negative range, sign checked separately
  assign h_mag = CW'(hue_i[hsvrgb_pkg::IN_W-2:0]);
  assign s_mag = CW'(saturation_i[hsvrgb_pkg::IN_W-2:0]);
  assign v_mag = CW'(brightness_i[hsvrgb_pkg::IN_W-2:0]);

  assign h_ok = !hue_i[hsvrgb_pkg::IN_W-1] && (h_mag <= ONE_C);
  assign s_ok = !saturation_i[hsvrgb_pkg::IN_W-1] && (s_mag <= ONE_C);
  assign v_ok = !brightness_i[hsvrgb_pkg::IN_W-1] && (v_mag <= ONE_C);

  // hue * 6, then integer part is the sector
  assign h6     = HW'(h_mag[VW-1:0]) * HW'(3'd6);
  assign sector = h6[FRAC_BITS+2:FRAC_BITS];
  assign f_raw  = {1'b0, h6[FRAC_BITS-1:0]};

  // classify; mirror fraction in even sectors
  always_comb begin
    if (!(s_ok && v_ok)) begin
      ctrl_o.kind = hsvrgb_pkg::KIND_BLACK;
    end else if (!h_ok) begin
      ctrl_o.kind = hsvrgb_pkg::KIND_GREY;
    end else begin
      ctrl_o.kind = hsvrgb_pkg::KIND_COLOR;
    end
    ctrl_o.sector = sector;
    frac_o = sector[0] ? f_raw : (ONE_V - f_raw);
  end

  assign sat_o = s_mag[VW-1:0];
  assign val_o = v_mag[VW-1:0];

endmodule

// ----- sv/hsvrgb_fifo.sv -----
// hsvrgb_fifo: small register queue between front and back end.
// No dependencies.
module hsvrgb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/hsvrgb_back.sv -----
// hsvrgb_back: three-stage datapath computing m, n and the 8-bit channels.
// Depends on hsvrgb_pkg.
module hsvrgb_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  hsvrgb_pkg::ctrl_t               ctrl_i,
  input  logic [FRAC_BITS:0]              frac_i,
  input  logic [FRAC_BITS:0]              sat_i,
  input  logic [FRAC_BITS:0]              val_i,
  output logic                            valid_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    red_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    green_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    blue_o
);

  localparam int VW = FRAC_BITS + 1;
  localparam int PW = 2 * VW;
  localparam int BW = VW + 8;
  localparam logic [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;

  // channel scale by 255, truncated
  function automatic logic [hsvrgb_pkg::OUT_W-1:0] to_byte(input logic [VW-1:0] x);
    logic [BW-1:0] t;
    t = (BW'(x) << 8) - BW'(x);
    return t[FRAC_BITS+7:FRAC_BITS];
  endfunction

  // stage 1: m and s*f
  logic              vld1_q;
  hsvrgb_pkg::ctrl_t ctrl1_q;
  logic [VW-1:0]     v1_q, m1_q, sf1_q;
  logic [PW-1:0]     pm, psf;

  assign pm  = PW'(val_i) * PW'(ONE_V - sat_i);
  assign psf = PW'(sat_i) * PW'(frac_i);

  // stage 2: n
  logic              vld2_q;
  hsvrgb_pkg::ctrl_t ctrl2_q;
  logic [VW-1:0]     v2_q, m2_q, n2_q;
  logic [PW-1:0]     pn;

  assign pn = PW'(v1_q) * PW'(ONE_V - sf1_q);

  // stage 3: channel order and byte scale
  logic                          vld3_q;
  logic [hsvrgb_pkg::OUT_W-1:0]  r_q, g_q, b_q, r_d, g_d, b_d;
  logic [VW-1:0]                 rx, gx, bx;

  always_comb begin
    case (ctrl2_q.sector)
      hsvrgb_pkg::SECT_1: begin rx = n2_q; gx = v2_q; bx = m2_q; end
      hsvrgb_pkg::SECT_2: begin rx = m2_q; gx = v2_q; bx = n2_q; end
      hsvrgb_pkg::SECT_3: begin rx = m2_q; gx = n2_q; bx = v2_q; end
      hsvrgb_pkg::SECT_4: begin rx = n2_q; gx = m2_q; bx = v2_q; end
      hsvrgb_pkg::SECT_5: begin rx = v2_q; gx = m2_q; bx = n2_q; end
      default:            begin rx = v2_q; gx = n2_q; bx = m2_q; end
    endcase
    case (ctrl2_q.kind)
      hsvrgb_pkg::KIND_COLOR: begin
        r_d = to_byte(rx);
        g_d = to_byte(gx);
        b_d = to_byte(bx);
      end
      hsvrgb_pkg::KIND_GREY: begin
        r_d = to_byte(v2_q);
        g_d = r_d;
        b_d = r_d;
      end
      default: begin
        r_d = '0;
        g_d = '0;
        b_d = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ctrl1_q <= ctrl_i;
    v1_q    <= val_i;
    m1_q    <= pm[FRAC_BITS+VW-1:FRAC_BITS];
    sf1_q   <= psf[FRAC_BITS+VW-1:FRAC_BITS];
    ctrl2_q <= ctrl1_q;
    v2_q    <= v1_q;
    m2_q    <= m1_q;
    n2_q    <= pn[FRAC_BITS+VW-1:FRAC_BITS];
    r_q     <= r_d;
    g_q     <= g_d;
    b_q     <= b_d;
  end

  assign valid_o = vld3_q;
  assign red_o   = r_q;
  assign green_o = g_q;
  assign blue_o  = b_q;

endmodule

// ----- sv/hsvrgb_checker.sv -----
// hsvrgb_checker: port-level timing and special-case checks, bound to the top level.
// Depends on hsvrgb_pkg and hsv_to_rgb_convert.
module hsvrgb_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic signed [hsvrgb_pkg::IN_W-1:0]  hue_i,
  input logic signed [hsvrgb_pkg::IN_W-1:0]  saturation_i,
  input logic signed [hsvrgb_pkg::IN_W-1:0]  brightness_i,
  input logic                                valid_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]        red_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]        green_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]        blue_o
);

  localparam int ONE_I = 1 << FRAC_BITS;

  logic beat, sv_ok;

  assign beat  = start && !busy;
  assign sv_ok = ($signed(saturation_i) >= 0) && (int'(saturation_i) <= ONE_I)
              && ($signed(brightness_i) >= 0) && (int'(brightness_i) <= ONE_I);

  // back end never stalls, so the queue never fills
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // every beat yields one result on valid_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni) beat |-> ##4 valid_o)
    else $error("result missing after accepted beat");

  // no result without an accepted beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(beat, 4))
    else $error("result without accepted beat");

  // negative saturation gives black
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && saturation_i[hsvrgb_pkg::IN_W-1]) |-> ##4
    (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("out-of-range saturation not black");

  // negative hue with valid s, v gives grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && hue_i[hsvrgb_pkg::IN_W-1] && sv_ok) |-> ##4
    (red_o == green_o && green_o == blue_o))
    else $error("out-of-range hue not grey");

endmodule

bind hsv_to_rgb_convert hsvrgb_checker #(.FRAC_BITS(FRAC_BITS)) u_hsvrgb_checker (.*);
